FILE: hw/rtl/utfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package utfd_pkg;

   localparam int unsigned OffsetWidth = 5;
   localparam int unsigned SecsWidth = 32;
   localparam int unsigned DaysWidth = 16;
   localparam int unsigned SodWidth = 17;
   localparam int unsigned WordWidth = 16;

   localparam logic [16:0] SecsPerDay = 17'd86400;
   localparam logic [11:0] SecsPerHour = 12'd3600;
   localparam logic [25:0] DayRecip = 26'd50903316;
   localparam logic [15:0] HourRecip = 16'd37283;
   localparam logic [14:0] MinuteRecip = 15'd17477;
   localparam logic [17:0] CycleRecip = 18'd183735;
   localparam logic [11:0] YearRecip = 12'd2873;
   localparam logic [9:0] MonthRecip = 10'd857;
   localparam logic [10:0] CycleDays = 11'd1461;
   localparam logic [8:0] YearDays = 9'd365;
   localparam logic [15:0] MarchEpochShift = 16'd671;
   localparam logic [15:0] Leap2100Day = 16'd47541;
   localparam logic [11:0] MarchEpochYear = 12'd1968;
   localparam logic [11:0] FatMinYear = 12'd1980;
   localparam logic [11:0] FatMaxYear = 12'd2107;

   typedef struct packed {
      logic [DaysWidth-1:0] days;
      logic [SodWidth-1:0]  sod;
   } split_type;

   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] start;
      unique case (mp)
         4'd0:    start = 9'd0;
         4'd1:    start = 9'd31;
         4'd2:    start = 9'd61;
         4'd3:    start = 9'd92;
         4'd4:    start = 9'd122;
         4'd5:    start = 9'd153;
         4'd6:    start = 9'd184;
         4'd7:    start = 9'd214;
         4'd8:    start = 9'd245;
         4'd9:    start = 9'd275;
         4'd10:   start = 9'd306;
         4'd11:   start = 9'd337;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/utfd_split.sv
`timescale 1ns / 1ps
`default_nettype none
module utfd_split (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic                           in_valid,
   input  wire logic [utfd_pkg::SecsWidth-1:0] in_seconds,
   input  wire logic [utfd_pkg::OffsetWidth-1:0] offset_hours,
   output logic                                out_valid,
   output utfd_pkg::split_type                 out_split
);
   import utfd_pkg::*;

   logic signed [17:0] off_secs;
   logic [31:0] local_in;
   logic [50:0] qprod;
   logic [32:0] dprod;
   logic [31:0] rem_full;

   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [31:0] s1_local_ff, s2_local_ff;
   logic [15:0] s2_q_ff, s3_q_ff;
   logic [17:0] s3_r_ff;
   split_type   s4_split_ff, s4_split_in;

   assign off_secs = 18'($signed(offset_hours) * $signed({1'b0, SecsPerHour}));
   assign local_in = in_seconds + {{14{off_secs[17]}}, off_secs};
   assign qprod = 51'(s1_local_ff[31:7]) * 51'(DayRecip);
   assign dprod = 33'(s2_q_ff) * 33'(SecsPerDay);
   assign rem_full = s2_local_ff - dprod[31:0];

   always_comb begin
      if (s3_r_ff >= 18'(SecsPerDay)) begin
         s4_split_in.days = s3_q_ff + 16'd1;
         s4_split_in.sod = 17'(s3_r_ff - 18'(SecsPerDay));
      end else begin
         s4_split_in.days = s3_q_ff;
         s4_split_in.sod = s3_r_ff[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s1_local_ff <= local_in;
         s2_local_ff <= s1_local_ff;
         s2_q_ff <= qprod[50:35];
         s3_q_ff <= s2_q_ff;
         s3_r_ff <= rem_full[17:0];
         s4_split_ff <= s4_split_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_split = s4_split_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/utfd_calendar.sv
`timescale 1ns / 1ps
`default_nettype none
module utfd_calendar (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            advance,
   input  wire logic                            in_valid,
   input  wire utfd_pkg::split_type             in_split,
   output logic                                 out_valid,
   output logic [utfd_pkg::WordWidth-1:0]       out_date,
   output logic [utfd_pkg::WordWidth-1:0]       out_time
);
   import utfd_pkg::*;

   logic        s5_valid_ff, s6_valid_ff, s7_valid_ff, s8_valid_ff, s9_valid_ff, s10_valid_ff;

   logic [15:0] z_in;
   logic [32:0] hprod;
   logic [33:0] cprod;
   logic [4:0]  s5_hour_ff;
   logic [16:0] s5_sod_ff;
   logic [15:0] s5_z_ff;
   logic [5:0]  s5_cyc_ff;

   logic [16:0] hsecs;
   logic [15:0] csum;
   logic [16:0] msec_full;
   logic [15:0] rem_full;
   logic [4:0]  s6_hour_ff;
   logic [11:0] s6_msec_ff;
   logic [10:0] s6_rem_ff;
   logic [5:0]  s6_cyc_ff;

   logic [26:0] mprod;
   logic [22:0] yprod;
   logic [4:0]  s7_hour_ff;
   logic [11:0] s7_msec_ff;
   logic [5:0]  s7_minute_ff;
   logic [10:0] s7_rem_ff;
   logic [2:0]  s7_yic_ff;
   logic [5:0]  s7_cyc_ff;

   logic [1:0]  yic;
   logic [11:0] msub;
   logic [10:0] ysub;
   logic [10:0] doy_full;
   logic [4:0]  s8_hour_ff, s9_hour_ff;
   logic [5:0]  s8_minute_ff, s9_minute_ff;
   logic [5:0]  s8_second_ff, s9_second_ff;
   logic [8:0]  s8_doy_ff, s9_doy_ff;
   logic [11:0] s8_yearm_ff, s9_yearm_ff;

   logic [10:0] tval;
   logic [20:0] tprod;
   logic [3:0]  s9_mp_ff;

   logic [8:0]  day_full;
   logic [3:0]  month;
   logic [11:0] year;
   logic [3:0]  month_c;
   logic [4:0]  day_c;
   logic [11:0] year_c;
   logic [11:0] year_rel;
   logic [15:0] date_ff, time_ff;

   assign z_in = in_split.days + MarchEpochShift + 16'(in_split.days >= Leap2100Day);
   assign hprod = 33'(in_split.sod) * 33'(HourRecip);
   assign cprod = 34'(z_in) * 34'(CycleRecip);

   assign hsecs = 17'(s5_hour_ff) * 17'(SecsPerHour);
   assign csum = 16'(s5_cyc_ff) * 16'(CycleDays);
   assign msec_full = s5_sod_ff - hsecs;
   assign rem_full = s5_z_ff - csum;

   assign mprod = 27'(s6_msec_ff) * 27'(MinuteRecip);
   assign yprod = 23'(s6_rem_ff) * 23'(YearRecip);

   assign yic = (s7_yic_ff > 3'd3) ? 2'd3 : s7_yic_ff[1:0];
   assign msub = 12'(s7_minute_ff) * 12'd60;
   assign ysub = 11'(yic) * 11'(YearDays);
   assign doy_full = s7_rem_ff - ysub;

   assign tval = 11'(s8_doy_ff) * 11'd5 + 11'd2;
   assign tprod = 21'(tval) * 21'(MonthRecip);

   always_comb begin
      day_full = s9_doy_ff - month_start(s9_mp_ff) + 9'd1;
      if (s9_mp_ff >= 4'd10) begin
         month = s9_mp_ff - 4'd9;
         year = s9_yearm_ff + 12'd1;
      end else begin
         month = s9_mp_ff + 4'd3;
         year = s9_yearm_ff;
      end
      priority if (year < FatMinYear) begin
         year_c = FatMinYear;
         month_c = 4'd1;
         day_c = 5'd1;
      end else if (year > FatMaxYear) begin
         year_c = FatMaxYear;
         month_c = month;
         day_c = day_full[4:0];
      end else begin
         year_c = year;
         month_c = month;
         day_c = day_full[4:0];
      end
      year_rel = year_c - FatMinYear;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
         s9_valid_ff <= 1'b0;
         s10_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= in_valid;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
         s8_valid_ff <= s7_valid_ff;
         s9_valid_ff <= s8_valid_ff;
         s10_valid_ff <= s9_valid_ff;
      end
      if (advance) begin
         s5_hour_ff <= hprod[31:27];
         s5_sod_ff <= in_split.sod;
         s5_z_ff <= z_in;
         s5_cyc_ff <= cprod[33:28];

         s6_hour_ff <= s5_hour_ff;
         s6_msec_ff <= msec_full[11:0];
         s6_rem_ff <= rem_full[10:0];
         s6_cyc_ff <= s5_cyc_ff;

         s7_hour_ff <= s6_hour_ff;
         s7_msec_ff <= s6_msec_ff;
         s7_minute_ff <= mprod[25:20];
         s7_rem_ff <= s6_rem_ff;
         s7_yic_ff <= yprod[22:20];
         s7_cyc_ff <= s6_cyc_ff;

         s8_hour_ff <= s7_hour_ff;
         s8_minute_ff <= s7_minute_ff;
         s8_second_ff <= 6'(s7_msec_ff - msub);
         s8_doy_ff <= doy_full[8:0];
         s8_yearm_ff <= MarchEpochYear + {4'd0, s7_cyc_ff, 2'd0} + 12'(yic);

         s9_hour_ff <= s8_hour_ff;
         s9_minute_ff <= s8_minute_ff;
         s9_second_ff <= s8_second_ff;
         s9_doy_ff <= s8_doy_ff;
         s9_yearm_ff <= s8_yearm_ff;
         s9_mp_ff <= tprod[20:17];

         date_ff <= {year_rel[6:0], month_c, day_c};
         time_ff <= {s9_hour_ff, s9_minute_ff, s9_second_ff[5:1]};
      end
   end

   assign out_valid = s10_valid_ff;
   assign out_date = date_ff;
   assign out_time = time_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/unix_time_to_fat_datetime.sv
`timescale 1ns / 1ps
`default_nettype none
// Converts a Unix timestamp, shifted by the local offset in whole hours, into
// FAT date and time words; one item enters every cycle unless the pipeline is
// stalled, and passes through the ten register stages of the divide-by-constant
// and calendar pipeline. rsp_stall freezes the whole pipeline while rsp_valid is high.
module unix_time_to_fat_datetime (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [utfd_pkg::OffsetWidth-1:0] csr_write_data,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [utfd_pkg::SecsWidth-1:0]   req_unix_seconds,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [utfd_pkg::WordWidth-1:0]        rsp_fat_date_word,
   output logic [utfd_pkg::WordWidth-1:0]        rsp_fat_time_word
);
   import utfd_pkg::*;

   logic [OffsetWidth-1:0] offset_ff;
   logic                   advance;
   logic                   split_valid;
   split_type              split;

   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_write_enable) begin
         offset_ff <= csr_write_data;
      end
   end

   utfd_split u_split (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_valid),
      .in_seconds   (req_unix_seconds),
      .offset_hours (offset_ff),
      .out_valid    (split_valid),
      .out_split    (split)
   );

   utfd_calendar u_calendar (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (split_valid),
      .in_split  (split),
      .out_valid (rsp_valid),
      .out_date  (rsp_fat_date_word),
      .out_time  (rsp_fat_time_word)
   );
endmodule
`default_nettype wire

FILE: hw/rtl/utfd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module utfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_fat_date_word,
   input wire logic [15:0] rsp_fat_time_word
);
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fat_date_word)
         && $stable(rsp_fat_time_word))
      else $error("Stalled result item changed.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fat_date_word[8:5] >= 4'd1 && rsp_fat_date_word[8:5] <= 4'd12
         && rsp_fat_date_word[4:0] != 5'd0)
      else $error("Result date has an invalid month or day.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fat_time_word[15:11] < 5'd24 && rsp_fat_time_word[10:5] < 6'd60
         && rsp_fat_time_word[4:0] < 5'd30)
      else $error("Result time of day is out of range.");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("Input stalled while the output was free.");
endmodule

bind unix_time_to_fat_datetime utfd_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_fat_date_word (rsp_fat_date_word),
   .rsp_fat_time_word (rsp_fat_time_word)
);
`default_nettype wire

FILE: tb/unix_time_to_fat_datetime_tb.sv
`timescale 1ns / 1ps
module unix_time_to_fat_datetime_tb;
   import utfd_pkg::*;

   typedef struct packed {
      logic [WordWidth-1:0] date_word;
      logic [WordWidth-1:0] time_word;
   } fat_stamp_type;

   typedef struct {
      logic [SecsWidth-1:0] secs;
      bit                   known;
      fat_stamp_type        stamp;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [OffsetWidth-1:0] csr_write_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [SecsWidth-1:0]   req_unix_seconds = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [WordWidth-1:0]   rsp_fat_date_word;
   logic [WordWidth-1:0]   rsp_fat_time_word;

   fat_stamp_type          pending_stamps[$];
   logic [OffsetWidth-1:0] zone_offset = '0;
   bit                     item_known = 1'b0;
   fat_stamp_type          item_stamp = '0;
   int unsigned            cycle_count = 0;
   int unsigned            error_count = 0;
   bit                     calm;

   unix_time_to_fat_datetime DUT (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_unix_seconds(req_unix_seconds),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_fat_date_word(rsp_fat_date_word), .rsp_fat_time_word(rsp_fat_time_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit leap_year(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic fat_stamp_type convert_stamp(input logic [SecsWidth-1:0] secs,
                                                   input logic [OffsetWidth-1:0] offs);
      logic [31:0] shift;
      logic [31:0] local_secs;
      int unsigned sod, days, year, month, day, mlen;
      int unsigned days_in_month[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      fat_stamp_type r;
      shift = {{(32-OffsetWidth){offs[OffsetWidth-1]}}, offs};
      local_secs = secs + shift * 32'd3600;
      sod = local_secs % 86400;
      days = local_secs / 86400;
      year = 1970;
      while (days >= (leap_year(year) ? 366 : 365)) begin
         days -= leap_year(year) ? 366 : 365;
         year++;
      end
      month = 0;
      while (month < 11) begin
         mlen = (month == 1 && leap_year(year)) ? 29 : days_in_month[month];
         if (days < mlen) break;
         days -= mlen;
         month++;
      end
      month += 1;
      day = days + 1;
      if (year < 1980) begin
         year = 1980;
         month = 1;
         day = 1;
      end else if (year > 2107) begin
         year = 2107;
      end
      r.date_word = 16'(((year - 1980) << 9) | ((month & 15) << 5) | (day & 31));
      r.time_word = 16'(((sod / 3600) << 11) | (((sod % 3600) / 60) << 5) | ((sod % 60) >> 1));
      return r;
   endfunction

   assign calm = (cycle_count >= 400) && (cycle_count < 900);

   always @(posedge clock) begin
      fat_stamp_type want;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 12);
         if (csr_write_enable) zone_offset <= csr_write_data;
         if (req_valid && !req_stall)
            pending_stamps.push_back(item_known ? item_stamp
                                     : convert_stamp(req_unix_seconds, zone_offset));
         if (rsp_valid && !rsp_stall) begin
            if (pending_stamps.size() == 0) begin
               $display("%0t: unexpected item date=%h time=%h", $time,
                        rsp_fat_date_word, rsp_fat_time_word);
               error_count++;
            end else begin
               want = pending_stamps.pop_front();
               if (want.date_word !== rsp_fat_date_word) begin
                  $display("%0t: date expected %h actual %h", $time, want.date_word,
                           rsp_fat_date_word);
                  error_count++;
               end
               if (want.time_word !== rsp_fat_time_word) begin
                  $display("%0t: time expected %h actual %h", $time, want.time_word,
                           rsp_fat_time_word);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic send_item(input logic [SecsWidth-1:0] secs, input bit known,
                            input fat_stamp_type stamp);
      while (!calm && ($urandom_range(0, 99) < 12)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_unix_seconds <= secs;
      item_known <= known;
      item_stamp <= stamp;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_stamps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_offset(input logic [OffsetWidth-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [SecsWidth-1:0] pick_secs();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 40 * 86400);
         1: return 32'd315532800 - 32'd200000 + $urandom_range(0, 400000);
         2: return 32'hFFFF_FFFF - $urandom_range(0, 400000);
         3: return 32'd951782400 + $urandom_range(0, 3) * 32'd126230400
                   + $urandom_range(0, 3 * 86400) - 32'd86400;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      stim_row_type rows[$];
      logic [4:0]   offsets[8] = '{5'b10100, 5'b01110, 5'b10000, 5'b01111,
                                   5'b11111, 5'b00000, 5'b00001, 5'b00000};
      rows.push_back('{32'd0, 1, '{16'h0021, 16'h0000}});
      rows.push_back('{32'd315532800, 1, '{16'h0021, 16'h0000}});
      rows.push_back('{32'd315532799, 1, '{16'h0021, 16'hBF7D}});
      rows.push_back('{32'hFFFF_FFFF, 1, '{16'hFC47, 16'h3387}});
      rows.push_back('{32'h8000_0000, 0, '0});
      rows.push_back('{32'h7FFF_FFFF, 0, '0});
      rows.push_back('{32'h5555_5555, 0, '0});
      rows.push_back('{32'hAAAA_AAAA, 0, '0});
      rows.push_back('{32'd951782400, 0, '0});
      rows.push_back('{32'd951868800, 0, '0});
      rows.push_back('{32'd946684799, 0, '0});
      rows.push_back('{32'd1078012800, 0, '0});
      rows.push_back('{32'd4107542399, 0, '0});
      rows.push_back('{32'd86399, 0, '0});
      rows.push_back('{32'd1, 0, '0});
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) send_item(rows[i].secs, rows[i].known, rows[i].stamp);
      drain();
      write_offset(5'b11111);
      for (int k = 0; k < 4; k++) send_item(32'(k * 1200), 0, '0);
      drain();
      for (int p = 0; p < 8; p++) begin
         write_offset(p >= 5 ? 5'($urandom()) : offsets[p]);
         for (int n = 0; n < 80; n++) begin
            if (p == 2 && n == 40) drain();
            send_item(pick_secs(), 0, '0);
         end
         drain();
      end
      if (error_count == 0) begin
         $display("unix_time_to_fat_datetime: match");
      end else begin
         $display("unix_time_to_fat_datetime: mismatch");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("unix_time_to_fat_datetime: mismatch");
      $finish;
   end

endmodule
